[sv/selective_arq_retransmit_tracker_top_defines.svh]
// assertion macros for the retransmission tracker
`ifndef SELECTIVE_ARQ_RETRANSMIT_TRACKER_TOP_DEFINES_SVH
`define SELECTIVE_ARQ_RETRANSMIT_TRACKER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// clocked check, off while reset is asserted
`define SART_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check that also holds during reset
`define SART_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SART_ASSERT(lbl, clk, rst_n, prop, msg)
`define SART_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[sv/sart_pkg.sv]
// types, constants and helpers of the retransmission tracker
package sart_pkg;

  localparam int unsigned SLOTS     = 8;
  localparam int unsigned SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SEQ_W     = 8;
  localparam int unsigned ATT_W     = 4;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned CNT_W     = 32;
  localparam int unsigned OC_W      = 3;
  localparam int unsigned SLOT_FW   = 3;
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 16;

  localparam logic [SLOT_W-1:0] LAST_IDX    = SLOT_W'(SLOTS - 1);
  localparam logic [TMO_W-1:0]  TIMEOUT_RST = TMO_W'(500);
  localparam logic [ATT_W-1:0]  MAX_ATT_RST = ATT_W'(3);

  typedef enum logic [OP_W-1:0] {
    OP_PLAIN = 2'd0,
    OP_TRACK = 2'd1,
    OP_ACK   = 2'd2,
    OP_TICK  = 2'd3
  } op_e;

  typedef enum logic [OC_W-1:0] {
    OC_NOTHING = 3'd0,
    OC_PLAIN   = 3'd1,
    OC_TRACKED = 3'd2,
    OC_ACKED   = 3'd3,
    OC_UNKNOWN = 3'd4,
    OC_RETX    = 3'd5,
    OC_GAVEUP  = 3'd6,
    OC_ENCFAIL = 3'd7
  } outcome_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIMEOUT = 1'b0,
    CFG_MAX_ATT = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    outcome_e             outcome;
    logic [SEQ_W-1:0]     seq;
    logic [SLOT_FW-1:0]   slot;
    logic                 evicted;
    logic [CNT_W-1:0]     drops;
    logic [CNT_W-1:0]     retx;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic [SEQ_W-1:0]  seq;
    logic [ATT_W-1:0]  att;
    logic [TIME_W-1:0] due;
  } entry_t;

  function automatic result_t mk_res(input outcome_e oc, input logic [SEQ_W-1:0] sq,
                                     input logic [SLOT_W-1:0] sl, input logic ev,
                                     input logic [CNT_W-1:0] drops,
                                     input logic [CNT_W-1:0] retx);
    result_t r;
    r.outcome = oc;
    r.seq     = sq;
    r.slot    = SLOT_FW'(sl);
    r.evicted = ev;
    r.drops   = drops;
    r.retx    = retx;
    r.last    = 1'b0;
    return r;
  endfunction

endpackage

[sv/sart_ifs.sv]
// item channels of the retransmission tracker

interface sart_in_if import sart_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SEQ_W-1:0]  ack_seq;
  logic [TIME_W-1:0] now_ms;
  logic              frame_ok;

  modport source (output valid, op, ack_seq, now_ms, frame_ok, input ready);
  modport sink   (input valid, op, ack_seq, now_ms, frame_ok, output ready);
endinterface

interface sart_out_if import sart_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OC_W-1:0]    outcome;
  logic [SEQ_W-1:0]   seq;
  logic [SLOT_FW-1:0] slot;
  logic               evicted;
  logic [CNT_W-1:0]   drop_count;
  logic [CNT_W-1:0]   retransmit_count;
  logic               last;

  modport source (output valid, outcome, seq, slot, evicted, drop_count, retransmit_count,
                  last, input ready);
  modport sink   (input valid, outcome, seq, slot, evicted, drop_count, retransmit_count,
                  last, output ready);
endinterface

[sv/selective_arq_retransmit_tracker_top.sv]
// selective-repeat retransmission tracker: slot table, send, ack and tick handling
// plain send, failed encode or tracked send into a free slot: result built on accept, pushed from S_FINISH
// ack, tick and tracked send with eviction walk the slot memory through S_READ and S_EVAL,
// as the slot memory read data is registered from the walk index
// throughput: one item at a time; the next item is taken once its closing result is pushed
// reset: used bits, counters and sequence number cleared, config loaded with reset values
`include "selective_arq_retransmit_tracker_top_defines.svh"

module selective_arq_retransmit_tracker_top import sart_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sart_in_if.sink              in_i,
  sart_out_if.source           out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // one-hot sequencer
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_EVAL   = 4'b0100,
    S_FINISH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [TMO_W-1:0] timeout_q;
  logic [ATT_W-1:0] max_att_q;

  // control state
  logic [SLOTS-1:0] used_q, used_d;
  logic [SEQ_W-1:0] next_seq_q, next_seq_d;
  logic [CNT_W-1:0] drops_q, drops_d;
  logic [CNT_W-1:0] retx_q, retx_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic             pend_vld_q, pend_vld_d;
  logic             out_vld_q;

  // item context and walk payload
  op_e               op_q, op_d;
  logic [SEQ_W-1:0]  ack_q, ack_d;
  logic [TIME_W-1:0] now_q, now_d;
  logic [SEQ_W-1:0]  seq_q, seq_d;
  logic [SLOT_W-1:0] best_q, best_d;
  logic [TIME_W-1:0] best_due_q, best_due_d;
  result_t           pend_q, pend_d;
  result_t           out_q;

  // slot memory: sequence number, attempts, due time
  entry_t            mem [SLOTS];
  entry_t            rdata_q;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  entry_t            mem_wdata;

  // output push
  logic    push;
  result_t push_res;
  logic    can_emit;
  logic    accept;

  // first free slot, found bit on top
  function automatic logic [SLOT_W:0] find_free(input logic [SLOTS-1:0] used);
    logic [SLOT_W:0] r;
    r = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!used[i]) r = {1'b1, SLOT_W'(i)};
    end
    return r;
  endfunction

  function automatic logic rearm_dummy_sign(input logic [TIME_W-1:0] diff);
    return diff[TIME_W-1];
  endfunction

  logic [SLOT_W:0]   free_slot;
  logic [TIME_W-1:0] rearm_now;   // due time from the accepted item's time
  logic [TIME_W-1:0] rearm_held;  // due time from the held item's time
  logic              is_last;
  logic              better;
  logic              due_now;

  assign accept     = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign can_emit   = !out_vld_q || out_o.ready;
  assign free_slot  = find_free(used_q);
  assign rearm_now  = in_i.now_ms + TIME_W'(timeout_q);
  assign rearm_held = now_q + TIME_W'(timeout_q);
  assign is_last    = (idx_q == LAST_IDX);
  // eviction candidate: smallest due time, first one wins on ties
  assign better     = (idx_q == '0) || (rdata_q.due < best_due_q);
  // due when now - due, modulo the time width, is not negative
  assign due_now    = !rearm_dummy_sign(now_q - rdata_q.due);

  always_comb begin
    state_d    = state_q;
    used_d     = used_q;
    next_seq_d = next_seq_q;
    drops_d    = drops_q;
    retx_d     = retx_q;
    idx_d      = idx_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;
    op_d       = op_q;
    ack_d      = ack_q;
    now_d      = now_q;
    seq_d      = seq_q;
    best_d     = best_q;
    best_due_d = best_due_q;
    mem_we     = 1'b0;
    mem_waddr  = idx_q;
    mem_wdata  = rdata_q;
    push       = 1'b0;
    push_res   = pend_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d  = op_e'(in_i.op);
          ack_d = in_i.ack_seq;
          now_d = in_i.now_ms;
          idx_d = '0;
          unique case (op_e'(in_i.op))
            OP_PLAIN, OP_TRACK: begin
              // every send takes a sequence number, even a failed one
              next_seq_d = next_seq_q + SEQ_W'(1);
              seq_d      = next_seq_q;
              pend_vld_d = 1'b1;
              state_d    = S_FINISH;
              if (!in_i.frame_ok) begin
                pend_d = mk_res(OC_ENCFAIL, next_seq_q, '0, 1'b0, drops_q, retx_q);
              end else if (op_e'(in_i.op) == OP_PLAIN) begin
                pend_d = mk_res(OC_PLAIN, next_seq_q, '0, 1'b0, drops_q, retx_q);
              end else if (free_slot[SLOT_W]) begin
                mem_we                         = 1'b1;
                mem_waddr                      = free_slot[SLOT_W-1:0];
                mem_wdata.seq                  = next_seq_q;
                mem_wdata.att                  = ATT_W'(1);
                mem_wdata.due                  = rearm_now;
                used_d[free_slot[SLOT_W-1:0]]  = 1'b1;
                pend_d = mk_res(OC_TRACKED, next_seq_q, free_slot[SLOT_W-1:0], 1'b0,
                                drops_q, retx_q);
              end else begin
                // table full: walk it for the earliest due time
                pend_vld_d = 1'b0;
                state_d    = S_READ;
              end
            end
            OP_ACK, OP_TICK: begin
              state_d = S_READ;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      S_READ: begin
        // free slots hold nothing an ack or tick cares about
        if (op_q != OP_TRACK && !used_q[idx_q]) begin
          if (is_last) state_d = S_FINISH;
          else         idx_d   = idx_q + SLOT_W'(1);
        end else begin
          state_d = S_EVAL;
        end
      end

      S_EVAL: begin
        unique case (op_q)
          OP_TRACK: begin
            if (is_last) begin
              mem_we        = 1'b1;
              mem_waddr     = better ? idx_q : best_q;
              mem_wdata.seq = seq_q;
              mem_wdata.att = ATT_W'(1);
              mem_wdata.due = rearm_held;
              drops_d       = drops_q + CNT_W'(1);
              pend_d        = mk_res(OC_TRACKED, seq_q, better ? idx_q : best_q, 1'b1,
                                     drops_q + CNT_W'(1), retx_q);
              pend_vld_d    = 1'b1;
              state_d       = S_FINISH;
            end else begin
              if (better) begin
                best_d     = idx_q;
                best_due_d = rdata_q.due;
              end
              idx_d   = idx_q + SLOT_W'(1);
              state_d = S_READ;
            end
          end
          OP_ACK: begin
            if (rdata_q.seq == ack_q) begin
              used_d[idx_q] = 1'b0;
              pend_d        = mk_res(OC_ACKED, ack_q, idx_q, 1'b0, drops_q, retx_q);
              pend_vld_d    = 1'b1;
              state_d       = S_FINISH;
            end else if (is_last) begin
              state_d = S_FINISH;
            end else begin
              idx_d   = idx_q + SLOT_W'(1);
              state_d = S_READ;
            end
          end
          OP_TICK: begin
            if (!due_now || !pend_vld_q || can_emit) begin
              if (due_now) begin
                // the held result is not the final one: send it on
                push     = pend_vld_q;
                push_res = pend_q;
                if (rdata_q.att >= max_att_q) begin
                  used_d[idx_q] = 1'b0;
                  drops_d       = drops_q + CNT_W'(1);
                  pend_d = mk_res(OC_GAVEUP, rdata_q.seq, idx_q, 1'b0,
                                  drops_q + CNT_W'(1), retx_q);
                end else begin
                  mem_we        = 1'b1;
                  mem_waddr     = idx_q;
                  mem_wdata.seq = rdata_q.seq;
                  mem_wdata.att = rdata_q.att + ATT_W'(1);
                  mem_wdata.due = rearm_held;
                  retx_d        = retx_q + CNT_W'(1);
                  pend_d = mk_res(OC_RETX, rdata_q.seq, idx_q, 1'b0,
                                  drops_q, retx_q + CNT_W'(1));
                end
                pend_vld_d = 1'b1;
              end
              if (is_last) begin
                state_d = S_FINISH;
              end else begin
                idx_d   = idx_q + SLOT_W'(1);
                state_d = S_READ;
              end
            end
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_FINISH: begin
        if (can_emit) begin
          push = 1'b1;
          if (pend_vld_q)          push_res = pend_q;
          else if (op_q == OP_ACK) push_res = mk_res(OC_UNKNOWN, ack_q, '0, 1'b0,
                                                     drops_q, retx_q);
          else                     push_res = mk_res(OC_NOTHING, '0, '0, 1'b0,
                                                     drops_q, retx_q);
          push_res.last = 1'b1;
          pend_vld_d    = 1'b0;
          state_d       = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      used_q     <= '0;
      next_seq_q <= '0;
      drops_q    <= '0;
      retx_q     <= '0;
      idx_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      next_seq_q <= next_seq_d;
      drops_q    <= drops_d;
      retx_q     <= retx_d;
      idx_q      <= idx_d;
      pend_vld_q <= pend_vld_d;
      if (push)             out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RST;
      max_att_q <= MAX_ATT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_TIMEOUT: timeout_q <= cfg_wdata_i[TMO_W-1:0];
        CFG_MAX_ATT: max_att_q <= cfg_wdata_i[ATT_W-1:0];
        default:     timeout_q <= timeout_q;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    ack_q      <= ack_d;
    now_q      <= now_d;
    seq_q      <= seq_d;
    best_q     <= best_d;
    best_due_q <= best_due_d;
    pend_q     <= pend_d;
    if (push) out_q <= push_res;
  end

  // slot memory, read address is the walk index
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[idx_q];
  end

  assign out_o.valid            = out_vld_q;
  assign out_o.outcome          = out_q.outcome;
  assign out_o.seq              = out_q.seq;
  assign out_o.slot             = out_q.slot;
  assign out_o.evicted          = out_q.evicted;
  assign out_o.drop_count       = out_q.drops;
  assign out_o.retransmit_count = out_q.retx;
  assign out_o.last             = out_q.last;

  // an accepted item always starts work
  `SART_ASSERT(a_accept_busy, clk_i, rst_ni, accept |=> (state_q != S_IDLE), "item accepted but sequencer stayed idle")
  // drops grow by at most one per cycle
  `SART_ASSERT(a_drop_step, clk_i, rst_ni, 1'b1 |=> ((drops_q == $past(drops_q)) || (drops_q == $past(drops_q) + CNT_W'(1))), "drop count jumped")
  // no result is held over into idle
  `SART_ASSERT(a_idle_no_pend, clk_i, rst_ni, (state_q == S_IDLE) |-> !pend_vld_q, "held result left behind")
  // eviction only when every slot is in use
  `SART_ASSERT(a_evict_full, clk_i, rst_ni, (state_q == S_EVAL && op_q == OP_TRACK && mem_we) |-> (&used_q), "eviction with a free slot")
  // a result is only pushed when the output register can take it
  `SART_ASSERT_ALWAYS(a_push_room, clk_i, push |-> can_emit, "result pushed over a waiting one")

endmodule

[tb/tb_selective_arq_retransmit_tracker_top.sv]
// self-checking testbench for the selective-repeat retransmission tracker
module tb_selective_arq_retransmit_tracker_top;
  import sart_pkg::*;

  // slowest correct run stays far below this: every walk visits each slot at most once,
  // each item makes at most SLOTS results and the receiver stalls about 72 percent
  localparam int unsigned CYCLE_LIMIT  = 400000;
  // settle time after the last result, a bit more than one full slot walk
  localparam int unsigned DRAIN_CYCLES = 2 * SLOTS + 2 + 20;
  localparam int unsigned RECENT_MAX   = 12;
  localparam int unsigned PHASES       = 6;

  // one input item as handed to the tracker
  typedef struct {
    op_e               op;
    logic [SEQ_W-1:0]  ack_seq;
    logic [TIME_W-1:0] now_ms;
    logic              frame_ok;
  } tracker_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;

  sart_in_if  in_if ();
  sart_out_if out_if ();

  selective_arq_retransmit_tracker_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // predicted copy of the tracker: slot table, counters and registers
  // ---------------------------------------------------------------------------
  logic              slot_busy     [SLOTS];
  logic [SEQ_W-1:0]  slot_seqno    [SLOTS];
  logic [ATT_W-1:0]  slot_tries    [SLOTS];
  logic [TIME_W-1:0] slot_deadline [SLOTS];
  logic [SEQ_W-1:0]  seq_next;
  logic [CNT_W-1:0]  drop_total;
  logic [CNT_W-1:0]  retx_total;
  logic [TMO_W-1:0]  timeout_val;
  logic [ATT_W-1:0]  attempt_limit;

  result_t       expected_results [$];
  tracker_item_t pending_items [$];
  tracker_item_t cur_item;

  // stimulus bookkeeping
  logic [SEQ_W-1:0]  gen_seq;
  logic [TIME_W-1:0] gen_now;
  logic [SEQ_W-1:0]  recent_tracked [$];
  int unsigned       sends_made;

  int unsigned items_queued;
  int unsigned items_accepted;
  int unsigned results_checked;
  int unsigned reg_writes;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned outcome_seen [8];
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  logic [TMO_W-1:0] phase_tmo [PHASES];
  logic [ATT_W-1:0] phase_att [PHASES];

  // work out every result one accepted item causes and queue them in order
  task automatic predict_tracker(input tracker_item_t it);
    result_t           batch [$];
    result_t           r;
    logic [TIME_W-1:0] late;
    int                pick;
    int                oldest;
    int                i;
    r = '0;
    case (it.op)
      OP_PLAIN, OP_TRACK: begin
        // every send burns a sequence number, even when encoding failed
        r.seq    = seq_next;
        seq_next = seq_next + SEQ_W'(1);
        if (!it.frame_ok) begin
          r.outcome = OC_ENCFAIL;
        end else if (it.op == OP_PLAIN) begin
          r.outcome = OC_PLAIN;
        end else begin
          pick   = -1;
          oldest = 0;
          for (i = 0; i < SLOTS; i++) begin
            if (!slot_busy[i]) begin
              pick = i;
              break;
            end
            if (slot_deadline[i] < slot_deadline[oldest]) oldest = i;
          end
          if (pick < 0) begin
            // table full: the earliest deadline loses its slot
            pick       = oldest;
            r.evicted  = 1'b1;
            drop_total = drop_total + CNT_W'(1);
          end
          slot_seqno[pick]    = r.seq;
          slot_tries[pick]    = ATT_W'(1);
          slot_deadline[pick] = it.now_ms + TIME_W'(timeout_val);
          slot_busy[pick]     = 1'b1;
          r.outcome           = OC_TRACKED;
          r.slot              = SLOT_FW'(pick);
        end
        r.drops = drop_total;
        r.retx  = retx_total;
        batch.push_back(r);
      end
      OP_ACK: begin
        pick = -1;
        for (i = 0; i < SLOTS; i++) begin
          if (slot_busy[i] && slot_seqno[i] == it.ack_seq) begin
            pick = i;
            break;
          end
        end
        r.seq = it.ack_seq;
        if (pick >= 0) begin
          slot_busy[pick] = 1'b0;
          r.outcome       = OC_ACKED;
          r.slot          = SLOT_FW'(pick);
        end else begin
          r.outcome = OC_UNKNOWN;
        end
        r.drops = drop_total;
        r.retx  = retx_total;
        batch.push_back(r);
      end
      default: begin
        // tick: walk the slots in index order, one result per due slot
        for (i = 0; i < SLOTS; i++) begin
          late = it.now_ms - slot_deadline[i];
          if (slot_busy[i] && !late[TIME_W-1]) begin
            r      = '0;
            r.seq  = slot_seqno[i];
            r.slot = SLOT_FW'(i);
            if (slot_tries[i] >= attempt_limit) begin
              slot_busy[i] = 1'b0;
              drop_total   = drop_total + CNT_W'(1);
              r.outcome    = OC_GAVEUP;
            end else begin
              slot_tries[i]    = slot_tries[i] + ATT_W'(1);
              retx_total       = retx_total + CNT_W'(1);
              slot_deadline[i] = it.now_ms + TIME_W'(timeout_val);
              r.outcome        = OC_RETX;
            end
            r.drops = drop_total;
            r.retx  = retx_total;
            batch.push_back(r);
          end
        end
        if (batch.size() == 0) begin
          r         = '0;
          r.outcome = OC_NOTHING;
          r.drops   = drop_total;
          r.retx    = retx_total;
          batch.push_back(r);
        end
      end
    endcase
    // mark the closing result of this item
    r      = batch.pop_back();
    r.last = 1'b1;
    batch.push_back(r);
    foreach (batch[k]) expected_results.push_back(batch[k]);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: presents queued items, holds each until the tracker takes it
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_tracker(cur_item);
        items_accepted++;
      end
      // only move on when the slot is empty or the current item just went
      if (!in_if.valid || in_if.ready) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_item       = pending_items.pop_front();
          in_if.valid    <= 1'b1;
          in_if.op       <= cur_item.op;
          in_if.ack_seq  <= cur_item.ack_seq;
          in_if.now_ms   <= cur_item.now_ms;
          in_if.frame_ok <= cur_item.frame_ok;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: random back-pressure and field-by-field compare of each result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    result_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: outcome %0d seq %0d slot %0d",
                 out_if.outcome, out_if.seq, out_if.slot);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("outcome", want.outcome, out_if.outcome);
          check_field("seq", want.seq, out_if.seq);
          check_field("slot", want.slot, out_if.slot);
          check_field("evicted", want.evicted, out_if.evicted);
          check_field("drop_count", want.drops, out_if.drop_count);
          check_field("retransmit_count", want.retx, out_if.retransmit_count);
          check_field("last", want.last, out_if.last);
          outcome_seen[want.outcome]++;
          results_checked++;
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_selective_arq_retransmit_tracker_top NOT OK");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic add_item(input op_e op, input logic [SEQ_W-1:0] ack,
                          input logic [TIME_W-1:0] now, input logic ok);
    tracker_item_t it;
    it.op       = op;
    it.ack_seq  = ack;
    it.now_ms   = now;
    it.frame_ok = ok;
    pending_items.push_back(it);
    items_queued++;
    // mirror sequence numbering so acks can name frames still in flight
    if (op == OP_PLAIN || op == OP_TRACK) begin
      if (op == OP_TRACK && ok) begin
        recent_tracked.push_back(gen_seq);
        if (recent_tracked.size() > RECENT_MAX) void'(recent_tracked.pop_front());
      end
      gen_seq = gen_seq + SEQ_W'(1);
      sends_made++;
    end
  endtask

  // one random item; time mostly moves forward in steps scaled to the timeout
  task automatic gen_random(input int unsigned send_pct);
    int unsigned       r;
    int unsigned       k;
    op_e               op;
    logic [SEQ_W-1:0]  ack;
    logic [TIME_W-1:0] now;
    logic              ok;
    r   = $urandom_range(0, 99);
    ack = SEQ_W'($urandom());
    now = $urandom();
    ok  = ($urandom_range(0, 99) < 85);
    if (r < send_pct) begin
      op = ($urandom_range(0, 2) == 0) ? OP_PLAIN : OP_TRACK;
      if (op == OP_TRACK && $urandom_range(0, 19) != 0) now = gen_now;
    end else if (r < send_pct + (100 - send_pct) * 2 / 5) begin
      op = OP_ACK;
      // mostly acks for frames we know were tracked, some stale or unknown
      if (recent_tracked.size() > 0 && $urandom_range(0, 9) < 7) begin
        k   = $urandom_range(0, recent_tracked.size() - 1);
        ack = recent_tracked[k];
      end
    end else begin
      op = OP_TICK;
      k  = $urandom_range(0, 9);
      if (k < 6) begin
        gen_now = gen_now + TIME_W'($urandom_range(0, int'(timeout_val) / 2 + 1));
      end else if (k < 9) begin
        gen_now = gen_now + TIME_W'($urandom_range(0, int'(timeout_val) * 2 + 2));
      end else begin
        // clock jump, lands anywhere in the 32-bit range
        gen_now = $urandom();
      end
      now = gen_now;
    end
    add_item(op, ack, now, ok);
  endtask

  task automatic wait_drain();
    while (items_accepted != items_queued || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx == CFG_TIMEOUT) timeout_val = val[TMO_W-1:0];
    else attempt_limit = val[ATT_W-1:0];
    reg_writes++;
  endtask

  // both registers back to back, only while nothing is in flight
  task automatic apply_settings(input logic [TMO_W-1:0] tmo, input logic [ATT_W-1:0] att);
    logic [CFG_W-1:0] att_word;
    att_word           = CFG_W'($urandom());
    att_word[ATT_W-1:0] = att;
    write_reg(CFG_TIMEOUT, CFG_W'(tmo));
    write_reg(CFG_MAX_ATT, att_word);
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence of the run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned i;
    int unsigned p;
    in_if.valid    = 1'b0;
    in_if.op       = '0;
    in_if.ack_seq  = '0;
    in_if.now_ms   = '0;
    in_if.frame_ok = 1'b0;
    out_if.ready   = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = '0;
    cfg_wdata      = '0;
    for (i = 0; i < SLOTS; i++) begin
      slot_busy[i]     = 1'b0;
      slot_seqno[i]    = '0;
      slot_tries[i]    = '0;
      slot_deadline[i] = '0;
    end
    seq_next        = '0;
    drop_total      = '0;
    retx_total      = '0;
    timeout_val     = TIMEOUT_RST;
    attempt_limit   = MAX_ATT_RST;
    gen_seq         = '0;
    gen_now         = '0;
    sends_made      = 0;
    items_queued    = 0;
    items_accepted  = 0;
    results_checked = 0;
    reg_writes      = 0;
    fail_count      = 0;
    cycle_count     = 0;
    foreach (outcome_seen[k]) outcome_seen[k] = 0;
    // sender idles often-ish, receiver stalls most of the time
    send_idle_pct   = 18;
    recv_idle_pct   = 72;

    // extremes, degenerate timeout and attempt limit, mid-range and small settings, then fully random ones
    phase_tmo[0] = 16'hFFFF;                      phase_att[0] = 4'd15;
    phase_tmo[1] = 16'd1;                         phase_att[1] = 4'd1;
    phase_tmo[2] = 16'd0;                         phase_att[2] = 4'd0;
    phase_tmo[3] = TMO_W'($urandom_range(2, 2000)); phase_att[3] = ATT_W'($urandom_range(1, 15));
    phase_tmo[4] = 16'd7;                         phase_att[4] = 4'd2;
    phase_tmo[5] = TMO_W'($urandom());            phase_att[5] = ATT_W'($urandom());

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part with reset register values
    add_item(OP_PLAIN, 8'hFF, 32'h0000_0000, 1'b1);   // plain send
    add_item(OP_PLAIN, 8'h00, 32'hFFFF_FFFF, 1'b0);   // plain send, encoder failed
    add_item(OP_TRACK, 8'hAA, 32'h0000_0000, 1'b0);   // tracked send, encoder failed
    add_item(OP_TICK,  8'h55, 32'h0000_0000, 1'b0);   // tick on an empty table
    for (i = 0; i < SLOTS; i++)
      add_item(OP_TRACK, 8'h00, 32'(10 + i), 1'b1);  // fill every slot
    add_item(OP_TRACK, 8'h00, 32'd20, 1'b1);          // full table forces an eviction
    add_item(OP_ACK,   8'd5,  32'hFFFF_FFFF, 1'b1);   // ack of a tracked frame
    add_item(OP_ACK,   8'd5,  32'h0000_0000, 1'b0);   // same ack again, now unknown
    add_item(OP_ACK,   8'hFF, 32'h1234_5678, 1'b1);   // ack never sent
    add_item(OP_TICK,  8'hFF, 32'd511, 1'b1);         // single slot due
    add_item(OP_TICK,  8'h00, 32'd600, 1'b0);         // most slots due
    add_item(OP_TICK,  8'h00, 32'd2000, 1'b1);        // every busy slot is due and reaches the attempt limit
    add_item(OP_TICK,  8'h00, 32'd3000, 1'b1);        // every busy slot gives up
    add_item(OP_TICK,  8'h00, 32'hFFFF_FFFF, 1'b1);   // empty again
    add_item(OP_TRACK, 8'h00, 32'hFFFF_FFF0, 1'b1);   // due time wraps past zero
    add_item(OP_TICK,  8'h00, 32'h0000_0010, 1'b0);   // before the wrapped due time
    add_item(OP_TICK,  8'h00, 32'h8000_0000, 1'b1);   // far past it, still due
    wait_drain();

    for (p = 0; p < PHASES; p++) begin
      // idle mix swaps sides after the first third, last third runs without gaps
      if (p >= 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (p >= 2) begin
        send_idle_pct = 72;
        recv_idle_pct = 18;
      end
      apply_settings(phase_tmo[p], phase_att[p]);
      if (p == 3) gen_now = 32'hFFFF_FC00;  // let this phase cross the time wrap
      if (p < PHASES - 1) begin
        repeat (24) gen_random(55);
      end else begin
        // send-heavy stretch to close the run
        repeat (26) gen_random(88);
      end
      wait_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end

    $display("covered %0d items, %0d results, %0d register writes, %0d sends",
             items_accepted, results_checked, reg_writes, sends_made);
    $display("outcomes: none %0d plain %0d tracked %0d acked %0d unknown %0d retx %0d"
             , outcome_seen[0], outcome_seen[1], outcome_seen[2], outcome_seen[3],
             outcome_seen[4], outcome_seen[5]);
    $display("outcomes: gave up %0d encode failed %0d", outcome_seen[6], outcome_seen[7]);
    if (fail_count == 0) begin
      $display("tb_selective_arq_retransmit_tracker_top OK");
    end else begin
      $display("tb_selective_arq_retransmit_tracker_top NOT OK");
    end
    $finish;
  end

endmodule
